// File: rtl/handle_id_allocator_unit_defines.svh
// ---------------------------------------------------------------------------
// Handle ID allocator assertion macros
// Shared property macros for the concurrent checks of the allocator.
// ---------------------------------------------------------------------------
`ifndef HANDLE_ID_ALLOCATOR_UNIT_DEFINES_SVH
`define HANDLE_ID_ALLOCATOR_UNIT_DEFINES_SVH

// Antecedent and consequent in the same cycle.
`define HIA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("handle allocator check failed");

// Consequent in the cycle after the antecedent.
`define HIA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("handle allocator check failed");

`endif

// File: rtl/hia_pkg.sv
// ---------------------------------------------------------------------------
// Handle ID allocator package
// Types, codes and constants shared by the allocator modules.
// ---------------------------------------------------------------------------
`default_nettype none

package hia_pkg;

  localparam int unsigned CAPACITY  = 1024;
  localparam int unsigned ENTRY_W   = 10;
  localparam int unsigned COUNT_W   = 11;
  localparam int unsigned HANDLE_W  = 13;
  localparam int unsigned PAYLOAD_W = 32;
  localparam int unsigned TDATA_W   = 48;

  localparam logic [COUNT_W-1:0] CAPACITY_CNT    = COUNT_W'(CAPACITY);
  localparam logic [COUNT_W-1:0] COUNT_MAX       = '1;
  localparam logic [COUNT_W-1:0] THRESHOLD_RESET = COUNT_W'(256);

  typedef enum logic [1:0] {
    OP_ALLOC  = 2'd0,
    OP_FREE   = 2'd1,
    OP_LOOKUP = 2'd2
  } opcode_e;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_FULL = 2'd1,
    STAT_BAD  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_FRESH,
    ACT_POP,
    ACT_FREE,
    ACT_LOOKUP
  } action_e;

  typedef enum logic {
    S_IDLE,
    S_RUN
  } state_e;

  typedef struct packed {
    logic                 pay_we;
    logic                 pay_re;
    logic [ENTRY_W-1:0]   pay_addr;
    logic [PAYLOAD_W-1:0] pay_wdata;
    logic                 link_we;
    logic [ENTRY_W-1:0]   link_waddr;
    logic [ENTRY_W-1:0]   link_wdata;
    logic                 link_re;
    logic [ENTRY_W-1:0]   link_raddr;
  } mem_req_t;

  typedef struct packed {
    logic [PAYLOAD_W-1:0] pay_rdata;
    logic [ENTRY_W-1:0]   link_rdata;
  } mem_rsp_t;

  function automatic logic [HANDLE_W-1:0] encode_handle(input logic [ENTRY_W-1:0] entry);
    logic [COUNT_W-1:0] idx;
    idx = {1'b0, entry} + COUNT_W'(1);
    return {idx, 2'b00};
  endfunction

endpackage

`default_nettype wire

// File: rtl/handle_id_allocator_unit.sv
// ---------------------------------------------------------------------------
// Handle ID allocator unit
// Handle table engine with a FIFO free list held in on-chip memory.
// ---------------------------------------------------------------------------
// Requests arrive on the slave stream: allocate with a tag, free a handle, or
// look up the tag of a handle. Handles are (entry + 1) * 4. Each request
// gives exactly one response on the master stream with the allocated handle,
// the looked-up tag and a status code.
// Every request is handled first in S_IDLE, where the accept reads or writes the
// tag and link memories, and then in S_RUN, which takes the registered read data
// and updates the counters and list pointers. One request is in flight at a time,
// so a new request is not accepted until the engine has finished the previous one.
// The response register lets a new request be accepted while the previous
// response still waits; if the receiver stalls, the engine holds the finished
// request until the register drains, and stops accepting.
// Reset empties the table and the free list and sets the reuse threshold to
// 256; the memories need no clearing, as only written entries are ever read.
// The threshold is written through cfg_we_i and cfg_wdata_i; the user must write it only while idle (not enforced).
// ---------------------------------------------------------------------------
`default_nettype none

module handle_id_allocator_unit
  import hia_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [COUNT_W-1:0] cfg_wdata_i,
  input  wire logic               s_axis_tvalid,
  output logic                    s_axis_tready,
  // Fields from bit 0: opcode[1:0], handle_in[14:2], payload_in[46:15], zero[47].
  input  wire logic [TDATA_W-1:0] s_axis_tdata,
  output logic                    m_axis_tvalid,
  input  wire logic               m_axis_tready,
  // Fields from bit 0: handle_out[12:0], payload_out[44:13], status[46:45], zero[47].
  output logic [TDATA_W-1:0]      m_axis_tdata
);

  `include "handle_id_allocator_unit_defines.svh"

  mem_req_t mem_req;
  mem_rsp_t mem_rsp;

  hia_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .s_valid_i   (s_axis_tvalid),
    .s_ready_o   (s_axis_tready),
    .s_data_i    (s_axis_tdata),
    .m_valid_o   (m_axis_tvalid),
    .m_ready_i   (m_axis_tready),
    .m_data_o    (m_axis_tdata),
    .req_o       (mem_req),
    .rsp_i       (mem_rsp)
  );

  hia_tables u_tables (
    .clk_i (clk_i),
    .req_i (mem_req),
    .rsp_o (mem_rsp)
  );

  `HIA_ASSERT_NEXT(a_one_in_flight, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, !s_axis_tready)
  `HIA_ASSERT_IMPL(a_fail_no_handle, clk_i, rst_ni, m_axis_tvalid && (m_axis_tdata[46:45] != STAT_OK), m_axis_tdata[12:0] == '0)
  `HIA_ASSERT_IMPL(a_handle_aligned, clk_i, rst_ni, m_axis_tvalid, m_axis_tdata[1:0] == 2'b00)

endmodule

`default_nettype wire

// File: rtl/hia_tables.sv
// ---------------------------------------------------------------------------
// Handle ID allocator tables
// Tag memory and free-list link memory, one write and one read per cycle each,
// with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module hia_tables
  import hia_pkg::*;
(
  input  wire logic     clk_i,
  input  wire mem_req_t req_i,
  output mem_rsp_t      rsp_o
);

  logic [PAYLOAD_W-1:0] pay_mem  [CAPACITY];
  logic [ENTRY_W-1:0]   link_mem [CAPACITY];
  logic [PAYLOAD_W-1:0] pay_rdata_q;
  logic [ENTRY_W-1:0]   link_rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.pay_we) begin
      pay_mem[req_i.pay_addr] <= req_i.pay_wdata;
    end
    if (req_i.pay_re) begin
      pay_rdata_q <= pay_mem[req_i.pay_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.link_we) begin
      link_mem[req_i.link_waddr] <= req_i.link_wdata;
    end
    if (req_i.link_re) begin
      link_rdata_q <= link_mem[req_i.link_raddr];
    end
  end

  assign rsp_o.pay_rdata  = pay_rdata_q;
  assign rsp_o.link_rdata = link_rdata_q;

endmodule

`default_nettype wire

// File: rtl/hia_ctrl.sv
// ---------------------------------------------------------------------------
// Handle ID allocator control
// Decodes each request, drives the table accesses, keeps the fresh counter
// and the free-list pointers, and holds the result register.
// ---------------------------------------------------------------------------
`default_nettype none

module hia_ctrl
  import hia_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [COUNT_W-1:0]  cfg_wdata_i,
  input  wire logic                s_valid_i,
  output logic                     s_ready_o,
  input  wire logic [TDATA_W-1:0]  s_data_i,
  output logic                     m_valid_o,
  input  wire logic                m_ready_i,
  output logic [TDATA_W-1:0]       m_data_o,
  output mem_req_t                 req_o,
  input  wire mem_rsp_t            rsp_i
);

  state_e state_q, state_d;

  logic [COUNT_W-1:0] thr_q;
  logic [COUNT_W-1:0] fresh_q, fresh_d;
  logic [ENTRY_W-1:0] head_q, head_d;
  logic [ENTRY_W-1:0] tail_q, tail_d;
  logic [COUNT_W-1:0] fcnt_q, fcnt_d;

  action_e              act_q, act;
  logic [ENTRY_W-1:0]   entry_q, entry;
  logic [HANDLE_W-1:0]  handle_q, handle;
  status_e              status_q, status;

  logic                 m_valid_q, m_valid_d;
  logic [TDATA_W-1:0]   m_data_q, m_data_d;

  logic [1:0]           in_op;
  logic [HANDLE_W-1:0]  in_handle;
  logic [PAYLOAD_W-1:0] in_tag;
  logic [COUNT_W-1:0]   h_idx;
  logic [COUNT_W-1:0]   h_entry;
  logic                 h_valid;
  logic                 can_fresh;
  logic                 can_pop;
  logic                 s_fire;
  logic                 out_free;
  logic                 complete;
  logic [PAYLOAD_W-1:0] res_payload;

  assign in_op     = s_data_i[1:0];
  assign in_handle = s_data_i[14:2];
  assign in_tag    = s_data_i[46:15];

  assign h_idx     = in_handle[HANDLE_W-1:2];
  assign h_entry   = h_idx - COUNT_W'(1);
  assign h_valid   = (h_idx != '0) && (in_handle[1:0] == 2'b00) && (h_entry < fresh_q);
  assign can_fresh = fresh_q < CAPACITY_CNT;
  assign can_pop   = (head_q != '0) && (fcnt_q >= thr_q);

  assign s_fire   = s_valid_i && s_ready_o;
  assign out_free = !m_valid_q || m_ready_i;
  assign complete = (state_q == S_RUN) && out_free;

  always_comb begin
    act    = ACT_NONE;
    entry  = '0;
    status = STAT_OK;
    case (in_op)
      OP_ALLOC: begin
        if (can_fresh) begin
          act   = ACT_FRESH;
          entry = fresh_q[ENTRY_W-1:0];
        end else if (can_pop) begin
          act   = ACT_POP;
          entry = head_q;
        end else begin
          status = STAT_FULL;
        end
      end
      OP_FREE: begin
        if (h_valid) begin
          act   = ACT_FREE;
          entry = h_entry[ENTRY_W-1:0];
        end else begin
          status = STAT_BAD;
        end
      end
      OP_LOOKUP: begin
        if (h_valid) begin
          act   = ACT_LOOKUP;
          entry = h_entry[ENTRY_W-1:0];
        end else begin
          status = STAT_BAD;
        end
      end
      default: begin
        status = STAT_BAD;
      end
    endcase
    handle = ((act == ACT_FRESH) || (act == ACT_POP)) ? encode_handle(entry) : '0;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (s_fire) begin
          state_d = S_RUN;
        end
      end
      S_RUN: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    s_ready_o = (state_q == S_IDLE);
    req_o     = '0;
    if (s_fire) begin
      case (act)
        ACT_FRESH, ACT_POP: begin
          req_o.pay_we     = 1'b1;
          req_o.pay_addr   = entry;
          req_o.pay_wdata  = in_tag;
          req_o.link_re    = (act == ACT_POP);
          req_o.link_raddr = head_q;
        end
        ACT_FREE: begin
          req_o.pay_we     = 1'b1;
          req_o.pay_addr   = entry;
          req_o.link_we    = (entry != '0);
          req_o.link_waddr = entry;
        end
        ACT_LOOKUP: begin
          req_o.pay_re   = 1'b1;
          req_o.pay_addr = entry;
        end
        default: begin
          req_o = '0;
        end
      endcase
    end
    if (complete && (act_q == ACT_FREE) && (entry_q != '0) && (tail_q != '0)) begin
      req_o.link_we    = 1'b1;
      req_o.link_waddr = tail_q;
      req_o.link_wdata = entry_q;
    end
  end

  always_comb begin
    fresh_d = fresh_q;
    head_d  = head_q;
    tail_d  = tail_q;
    fcnt_d  = fcnt_q;
    if (complete) begin
      case (act_q)
        ACT_FRESH: begin
          fresh_d = fresh_q + COUNT_W'(1);
        end
        ACT_POP: begin
          head_d = rsp_i.link_rdata;
          if (rsp_i.link_rdata == '0) begin
            tail_d = '0;
          end
          if (fcnt_q != '0) begin
            fcnt_d = fcnt_q - COUNT_W'(1);
          end
        end
        ACT_FREE: begin
          if (entry_q != '0) begin
            if (tail_q == '0) begin
              head_d = entry_q;
            end
            tail_d = entry_q;
            if (fcnt_q != COUNT_MAX) begin
              fcnt_d = fcnt_q + COUNT_W'(1);
            end
          end
        end
        default: begin
          fresh_d = fresh_q;
        end
      endcase
    end
  end

  assign res_payload = (act_q == ACT_LOOKUP) ? rsp_i.pay_rdata : '0;

  always_comb begin
    m_valid_d = m_valid_q;
    m_data_d  = m_data_q;
    if (complete) begin
      m_valid_d = 1'b1;
      m_data_d  = {1'b0, status_q, res_payload, handle_q};
    end else if (m_ready_i) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      thr_q     <= THRESHOLD_RESET;
      fresh_q   <= '0;
      head_q    <= '0;
      tail_q    <= '0;
      fcnt_q    <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      fresh_q   <= fresh_d;
      head_q    <= head_d;
      tail_q    <= tail_d;
      fcnt_q    <= fcnt_d;
      m_valid_q <= m_valid_d;
      if (cfg_we_i) begin
        thr_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    m_data_q <= m_data_d;
    if (s_fire) begin
      act_q    <= act;
      entry_q  <= entry;
      handle_q <= handle;
      status_q <= status;
    end
  end

  assign m_valid_o = m_valid_q;
  assign m_data_o  = m_data_q;

endmodule

`default_nettype wire
